>>> sv/limit_order_book_matcher_assert.svh
// assertion macros for the order book matcher
// used by the chain and the top level; needs a clk and rst in scope
`ifndef LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH
`define LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH

// same-cycle implication
`define LOBM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LOBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/lobm_pkg.sv
// shared constants, codes and types of the order book matcher
// no dependencies
package lobm_pkg;

  localparam int BOOK_DEPTH  = 32;
  localparam int IDX_W       = $clog2(BOOK_DEPTH);
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // request kinds
  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_CANCEL = 2'd1;
  localparam logic [1:0] FUNC_TRADE  = 2'd2;
  localparam logic [1:0] FUNC_TICK   = 2'd3;

  // result kinds
  localparam logic [3:0] KIND_ADD_OK    = 4'd0;
  localparam logic [3:0] KIND_DUPLICATE = 4'd1;
  localparam logic [3:0] KIND_FULL      = 4'd2;
  localparam logic [3:0] KIND_CANCEL_OK = 4'd3;
  localparam logic [3:0] KIND_NOT_FOUND = 4'd4;
  localparam logic [3:0] KIND_FILL      = 4'd5;
  localparam logic [3:0] KIND_NO_FILL   = 4'd6;
  localparam logic [3:0] KIND_UNSOL     = 4'd7;
  localparam logic [3:0] KIND_TICK_DONE = 4'd8;

  // scan modes of the probe
  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_BEST   = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;

  // slot commands
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_FILL  = 2'd3;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic [1:0]       mode;
    logic             side;
    logic [31:0]      key_id;
    logic [15:0]      arrival;
    logic [15:0]      lifetime;
    logic [1:0]       cmd_op;
    logic [IDX_W-1:0] cmd_idx;
    logic             cmd_side;
    logic [31:0]      cmd_price;
    logic [31:0]      cmd_rem;
    logic             cmd_ac;
  } bcast_t;

  // probe word handed from cell to cell
  typedef struct packed {
    logic             live;
    logic             match_hit;
    logic [IDX_W-1:0] match_idx;
    logic             free_hit;
    logic [IDX_W-1:0] free_idx;
    logic             best_hit;
    logic [IDX_W-1:0] best_idx;
    logic [31:0]      best_price;
    logic [15:0]      best_dist;
    logic [31:0]      best_id;
    logic [31:0]      best_rem;
    logic [CNT_W-1:0] cnt;
    logic             ev_hit;
    logic [31:0]      ev_id;
  } probe_t;

  // expiry event seen anywhere on the chain
  typedef struct packed {
    logic        hit;
    logic [31:0] id;
  } evt_t;

endpackage

>>> sv/limit_order_book_matcher.sv
// Order book matcher, top level: request sequencer, result staging and config.
// Channels: start/busy request port, strobe result port, cfg_valid/cfg_ready
// write port for the cancel lifetime (always ready, reset value 60).
// A request word is taken when start is high and busy is low. Each result word
// shows on the result ports for one cycle with strobe; last marks the final one.
// The receiver cannot stall, so every result is presented exactly once.
// Every search over the book is a probe word walking the row of slots, one
// slot a cycle.
// Add and cancel: one pass, then one result word, registered from the probe at the tail.
// Trade: k passes, k = fills plus one for each side that ends without a fill;
// each pass waits for the probe, then decides in the step state; a fill word shows one pass late.
// Tick: one pass that ages, expires and reports slots in order, one word per
// expired slot; the final word is the tick-done word when nothing expires,
// else the last expiry word, released in the finish state.
// A trade of size zero answers no fill in the cycle right after accept.
// The next request can be taken at the edge that ends the final word's cycle.
// Reset empties the book and clears the arrival counter; no clearing pass.
`include "limit_order_book_matcher_assert.svh"
module limit_order_book_matcher (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [31:0] req_id,
  input  logic        side,
  input  logic [31:0] price,
  input  logic [31:0] size,
  input  logic        auto_cancel,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output logic        strobe,
  output logic [3:0]  kind,
  output logic [31:0] result_order_id,
  output logic [31:0] fill_size,
  output logic [31:0] size_left,
  output logic        fully_filled,
  output logic        last
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WAIT = 2'd1;
  localparam logic [1:0] S_STEP = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]  state;
  logic [1:0]  mode;
  logic [1:0]  rfunc;
  logic [31:0] rid;
  logic        rside;
  logic [31:0] rprice;
  logic [31:0] rsize;
  logic        rac;
  logic [31:0] qty;
  logic        sd;
  logic        side_done;
  logic [lobm_pkg::CNT_W-1:0] n;
  logic [15:0] arrival;
  logic [15:0] lifetime;
  logic [1:0]  cmd_op;
  logic [lobm_pkg::IDX_W-1:0] cmd_idx;
  logic [31:0] cmd_rem;

  lobm_pkg::probe_t inj;
  lobm_pkg::probe_t tail;
  lobm_pkg::evt_t   evt;
  lobm_pkg::bcast_t bc;

  logic        accept;
  logic        fill_ok;
  logic [31:0] fsz;
  logic [31:0] newrem;
  logic        trade_done;
  logic        gen_v;
  logic [3:0]  gen_kind;
  logic [31:0] gen_id;
  logic [31:0] gen_fill;
  logic [31:0] gen_left;
  logic        gen_full;
  logic        fin;

  logic        pend_v;
  logic [3:0]  pkind;
  logic [31:0] pid;
  logic [31:0] pfill;
  logic [31:0] pleft;
  logic        pfull;

  assign busy = (state != S_IDLE);
  assign accept = start && !busy;
  assign cfg_ready = 1'b1;

  // broadcast word to the slots
  always_comb begin
    bc.mode = mode;
    bc.side = sd;
    bc.key_id = rid;
    bc.arrival = arrival;
    bc.lifetime = lifetime;
    bc.cmd_op = cmd_op;
    bc.cmd_idx = cmd_idx;
    bc.cmd_side = rside;
    bc.cmd_price = rprice;
    bc.cmd_rem = cmd_rem;
    bc.cmd_ac = rac;
  end

  lobm_chain u_chain (
    .clk       (clk),
    .rst       (rst),
    .bc        (bc),
    .probe_head(inj),
    .probe_tail(tail),
    .evt       (evt)
  );

  // fill arithmetic on the best order of the current side
  assign fill_ok = tail.best_hit &&
                   (sd ? (rprice > tail.best_price) : (rprice < tail.best_price));
  assign fsz = (qty < tail.best_rem) ? qty : tail.best_rem;
  assign newrem = tail.best_rem - fsz;
  assign trade_done = (qty == 32'd0) ||
                      (n == lobm_pkg::CNT_W'(lobm_pkg::MAX_RESULTS)) ||
                      (sd && side_done);

  // result generation
  always_comb begin
    gen_v = 1'b0;
    gen_kind = lobm_pkg::KIND_ADD_OK;
    gen_id = 32'd0;
    gen_fill = 32'd0;
    gen_left = 32'd0;
    gen_full = 1'b0;
    fin = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept && func == lobm_pkg::FUNC_TRADE && size == 32'd0) begin
          gen_v = 1'b1;
          gen_kind = lobm_pkg::KIND_NO_FILL;
          fin = 1'b1;
        end
      end
      S_WAIT: begin
        if (mode == lobm_pkg::MODE_TICK) begin
          if (evt.hit) begin
            gen_v = 1'b1;
            gen_kind = lobm_pkg::KIND_UNSOL;
            gen_id = evt.id;
          end
          if (tail.live && tail.cnt == '0) begin
            gen_v = 1'b1;
            gen_kind = lobm_pkg::KIND_TICK_DONE;
            fin = 1'b1;
          end
        end else if (tail.live) begin
          case (rfunc)
            lobm_pkg::FUNC_ADD: begin
              gen_v = 1'b1;
              gen_id = rid;
              fin = 1'b1;
              if (tail.match_hit) begin
                gen_kind = lobm_pkg::KIND_DUPLICATE;
              end else if (!tail.free_hit) begin
                gen_kind = lobm_pkg::KIND_FULL;
              end else begin
                gen_kind = lobm_pkg::KIND_ADD_OK;
              end
            end
            lobm_pkg::FUNC_CANCEL: begin
              gen_v = 1'b1;
              gen_id = rid;
              fin = 1'b1;
              gen_kind = tail.match_hit ? lobm_pkg::KIND_CANCEL_OK
                                        : lobm_pkg::KIND_NOT_FOUND;
            end
            default: begin
              if (fill_ok) begin
                gen_v = 1'b1;
                gen_kind = lobm_pkg::KIND_FILL;
                gen_id = tail.best_id;
                gen_fill = fsz;
                gen_left = newrem;
                gen_full = (newrem == 32'd0);
              end
            end
          endcase
        end
      end
      S_STEP: begin
        if (trade_done) begin
          fin = 1'b1;
          if (n == '0) begin
            gen_v = 1'b1;
            gen_kind = lobm_pkg::KIND_NO_FILL;
          end
        end
      end
      S_FIN: fin = 1'b1;
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      inj <= '0;
      cmd_op <= lobm_pkg::CMD_NONE;
      arrival <= 16'd0;
      lifetime <= 16'd60;
      mode <= lobm_pkg::MODE_LOOKUP;
    end else begin
      inj <= '0;
      cmd_op <= lobm_pkg::CMD_NONE;
      if (cfg_valid && cfg_ready) begin
        lifetime <= cfg_data;
      end
      // advance the arrival count as the new order lands in its slot
      if (cmd_op == lobm_pkg::CMD_WRITE) begin
        arrival <= arrival + 16'd1;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (func)
              lobm_pkg::FUNC_TRADE: begin
                mode <= lobm_pkg::MODE_BEST;
                if (size != 32'd0) begin
                  inj.live <= 1'b1;
                  state <= S_WAIT;
                end
              end
              lobm_pkg::FUNC_TICK: begin
                mode <= lobm_pkg::MODE_TICK;
                inj.live <= 1'b1;
                state <= S_WAIT;
              end
              default: begin
                mode <= lobm_pkg::MODE_LOOKUP;
                inj.live <= 1'b1;
                state <= S_WAIT;
              end
            endcase
          end
        end
        S_WAIT: begin
          if (tail.live) begin
            case (mode)
              lobm_pkg::MODE_TICK: state <= (tail.cnt == '0) ? S_IDLE : S_FIN;
              lobm_pkg::MODE_LOOKUP: begin
                state <= S_IDLE;
                if (rfunc == lobm_pkg::FUNC_ADD && !tail.match_hit && tail.free_hit) begin
                  cmd_op <= lobm_pkg::CMD_WRITE;
                  cmd_idx <= tail.free_idx;
                end
                if (rfunc == lobm_pkg::FUNC_CANCEL && tail.match_hit) begin
                  cmd_op <= lobm_pkg::CMD_CLEAR;
                  cmd_idx <= tail.match_idx;
                end
              end
              default: begin
                state <= S_STEP;
                if (fill_ok) begin
                  cmd_op <= lobm_pkg::CMD_FILL;
                  cmd_idx <= tail.best_idx;
                end
              end
            endcase
          end
        end
        S_STEP: begin
          if (trade_done) begin
            state <= S_IDLE;
          end else begin
            inj.live <= 1'b1;
            state <= S_WAIT;
          end
        end
        S_FIN: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // request and trade bookkeeping
  always_ff @(posedge clk) begin
    if (accept) begin
      rfunc <= func;
      rid <= req_id;
      rside <= side;
      rprice <= price;
      rsize <= size;
      rac <= auto_cancel;
      qty <= size;
      sd <= 1'b0;
      side_done <= 1'b0;
      n <= '0;
      cmd_rem <= size;
    end else if (state == S_WAIT && tail.live && mode == lobm_pkg::MODE_BEST) begin
      if (fill_ok) begin
        qty <= qty - fsz;
        n <= n + 1'b1;
        cmd_rem <= newrem;
        side_done <= 1'b0;
      end else begin
        side_done <= 1'b1;
      end
    end else if (state == S_STEP && !trade_done && !sd && side_done) begin
      sd <= 1'b1;
      side_done <= 1'b0;
    end else if (state == S_WAIT && tail.live && mode == lobm_pkg::MODE_LOOKUP) begin
      cmd_rem <= rsize;
    end
  end

  // output staging: hold one word so the final one can carry last
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      pend_v <= 1'b0;
    end else if (fin) begin
      strobe <= 1'b1;
      pend_v <= 1'b0;
    end else if (gen_v) begin
      strobe <= pend_v;
      pend_v <= 1'b1;
    end else begin
      strobe <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      kind <= pend_v ? pkind : gen_kind;
      result_order_id <= pend_v ? pid : gen_id;
      fill_size <= pend_v ? pfill : gen_fill;
      size_left <= pend_v ? pleft : gen_left;
      fully_filled <= pend_v ? pfull : gen_full;
      last <= 1'b1;
    end else if (gen_v) begin
      kind <= pkind;
      result_order_id <= pid;
      fill_size <= pfill;
      size_left <= pleft;
      fully_filled <= pfull;
      last <= 1'b0;
      pkind <= gen_kind;
      pid <= gen_id;
      pfill <= gen_fill;
      pleft <= gen_left;
      pfull <= gen_full;
    end
  end

  `LOBM_ASSERT_NOW(a_mid_busy, strobe && !last, busy, "non-final word while idle")
  `LOBM_ASSERT_NEXT(a_start_acts, accept, busy || strobe, "request took no effect")
  `LOBM_ASSERT_NOW(a_full_flag, strobe && kind == lobm_pkg::KIND_FILL,
    fully_filled == (size_left == 32'd0), "fill flag disagrees with remainder")

endmodule

>>> sv/lobm_cell.sv
// one book slot: holds a resting order and updates the passing probe word
// depends on lobm_pkg
module lobm_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [lobm_pkg::IDX_W-1:0] cell_idx,
  input  lobm_pkg::bcast_t          bc,
  input  lobm_pkg::probe_t          probe_in,
  output lobm_pkg::probe_t          probe_out
);

  logic        valid;
  logic [31:0] id;
  logic        side;
  logic [31:0] price;
  logic [31:0] rem;
  logic [15:0] age;
  logic        ac;
  logic [15:0] seq;

  lobm_pkg::probe_t po;
  logic        exp_now;
  logic        better;
  logic [15:0] age_inc;
  logic [15:0] gap;
  logic        cmd_hit;

  // probe update
  always_comb begin
    po = probe_in;
    po.ev_hit = 1'b0;
    po.ev_id = '0;
    exp_now = 1'b0;
    better = 1'b0;
    age_inc = (age == 16'hFFFF) ? age : age + 16'd1;
    gap = bc.arrival - seq;
    if (probe_in.live) begin
      case (bc.mode)
        lobm_pkg::MODE_LOOKUP: begin
          if (!probe_in.match_hit && valid && id == bc.key_id) begin
            po.match_hit = 1'b1;
            po.match_idx = cell_idx;
          end
          if (!probe_in.free_hit && !valid) begin
            po.free_hit = 1'b1;
            po.free_idx = cell_idx;
          end
        end
        lobm_pkg::MODE_BEST: begin
          if (valid && side == bc.side) begin
            // bids: highest then newest; asks: lowest then oldest
            if (!probe_in.best_hit) begin
              better = 1'b1;
            end else if (!bc.side) begin
              better = (price > probe_in.best_price) ||
                       (price == probe_in.best_price && gap < probe_in.best_dist);
            end else begin
              better = (price < probe_in.best_price) ||
                       (price == probe_in.best_price && gap > probe_in.best_dist);
            end
            if (better) begin
              po.best_hit = 1'b1;
              po.best_idx = cell_idx;
              po.best_price = price;
              po.best_dist = gap;
              po.best_id = id;
              po.best_rem = rem;
            end
          end
        end
        lobm_pkg::MODE_TICK: begin
          if (valid && ac && age_inc >= bc.lifetime &&
              probe_in.cnt < lobm_pkg::CNT_W'(lobm_pkg::MAX_RESULTS)) begin
            exp_now = 1'b1;
            po.cnt = probe_in.cnt + 1'b1;
            po.ev_hit = 1'b1;
            po.ev_id = id;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign cmd_hit = (bc.cmd_idx == cell_idx);

  // probe register and slot valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out <= '0;
      valid <= 1'b0;
    end else begin
      probe_out <= po;
      if (exp_now) begin
        valid <= 1'b0;
      end
      if (cmd_hit) begin
        case (bc.cmd_op)
          lobm_pkg::CMD_WRITE: valid <= 1'b1;
          lobm_pkg::CMD_CLEAR: valid <= 1'b0;
          lobm_pkg::CMD_FILL:  valid <= (bc.cmd_rem != 32'd0);
          default: begin
          end
        endcase
      end
    end
  end

  // slot payload
  always_ff @(posedge clk) begin
    if (probe_in.live && bc.mode == lobm_pkg::MODE_TICK && valid) begin
      age <= age_inc;
    end
    if (cmd_hit && bc.cmd_op == lobm_pkg::CMD_WRITE) begin
      id <= bc.key_id;
      side <= bc.cmd_side;
      price <= bc.cmd_price;
      rem <= bc.cmd_rem;
      age <= 16'd0;
      ac <= bc.cmd_ac;
      seq <= bc.arrival;
    end else if (cmd_hit && bc.cmd_op == lobm_pkg::CMD_FILL) begin
      rem <= bc.cmd_rem;
    end
  end

endmodule

>>> sv/lobm_chain.sv
// row of book slots with the probe word passed one cell per cycle
// depends on lobm_pkg, lobm_cell and the assertion macros header
`include "limit_order_book_matcher_assert.svh"
module lobm_chain (
  input  logic             clk,
  input  logic             rst,
  input  lobm_pkg::bcast_t bc,
  input  lobm_pkg::probe_t probe_head,
  output lobm_pkg::probe_t probe_tail,
  output lobm_pkg::evt_t   evt
);

  lobm_pkg::probe_t p [0:lobm_pkg::BOOK_DEPTH];
  logic [lobm_pkg::BOOK_DEPTH-1:0] live;

  assign p[0] = probe_head;

  // the cells
  for (genvar g = 0; g < lobm_pkg::BOOK_DEPTH; g++) begin : g_cell
    lobm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (lobm_pkg::IDX_W'(g)),
      .bc       (bc),
      .probe_in (p[g]),
      .probe_out(p[g+1])
    );
    assign live[g] = p[g+1].live;
  end

  assign probe_tail = p[lobm_pkg::BOOK_DEPTH];

  // gather the expiry event of whichever cell the probe just left
  always_comb begin
    evt = '0;
    for (int i = 1; i <= lobm_pkg::BOOK_DEPTH; i++) begin
      evt.hit = evt.hit | p[i].ev_hit;
      evt.id = evt.id | (p[i].ev_id & {32{p[i].ev_hit}});
    end
  end

  `LOBM_ASSERT_NOW(a_one_probe, 1'b1, $onehot0(live), "more than one probe on the chain")
  `LOBM_ASSERT_NOW(a_ev_live, evt.hit, |live, "expiry event without a live probe")

endmodule
